>>> hdl/mrfr_pkg.sv
// Shared codes, the fixed frame minimum and the CRC-16 byte update for the
// Modbus RTU receive framer. No dependencies.
package mrfr_pkg;

    // Item kinds on the input channel
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_EXPIRE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // Frame status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_CRC   = 2'd2;

    // A frame needs more than this many bytes to be complete
    localparam int FRAME_MIN = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Modbus CRC-16, reflected, one byte per call
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> hdl/mrfr_store.sv
// Frame byte store: one write port, one read port with registered data.
// No package dependencies.
module mrfr_store #(
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write on request; register read data, hold it between reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/modbus_rtu_frame_receiver.sv
// Modbus RTU receive framer: frame capture, CRC-16 check, stored data reads.
// Depends on mrfr_pkg and mrfr_store.
// A result is registered in stage 1 (store read) and then in the output register.
// Throughput: one item per cycle while the output is not stalled; the store has one write and one read port.
// Reset (rst_n, async, active low) clears control state; store contents stay
// undefined until written, and no clearing pass is needed.
module modbus_rtu_frame_receiver #(
    parameter int FRAME_MAX = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [7:0] rx_byte,
    input  logic       awaiting_response,
    input  logic [7:0] data_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       frame_ended,
    output logic       notify_response,
    output logic [1:0] frame_status,
    output logic [7:0] slave_id,
    output logic [7:0] function_code,
    output logic [7:0] data_length,
    output logic [7:0] read_data
);

    localparam int AW = $clog2(FRAME_MAX);
    localparam int CW = $clog2(FRAME_MAX + 1);

    // Frame control state
    logic          receiving_reg, receiving_next;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    slave_reg;
    logic [7:0]    func_reg;

    // Stage 1: store read in flight plus decoded result
    logic          s1_valid_reg;
    logic          s1_ended_reg;
    logic          s1_notify_reg;
    logic [1:0]    s1_status_reg;
    logic [7:0]    s1_slave_reg;
    logic [7:0]    s1_func_reg;
    logic [7:0]    s1_len_reg;
    logic          s1_hit_reg;

    // Stage 2: output register
    logic          out_valid_reg;
    logic          ended_reg;
    logic          notify_reg;
    logic [1:0]    status_reg;
    logic [7:0]    slave_out_reg;
    logic [7:0]    func_out_reg;
    logic [7:0]    len_reg;
    logic [7:0]    read_data_reg;

    logic          in_fire;
    logic          advance;
    logic          store_en;
    logic [CW-1:0] base_count;
    logic [15:0]   base_crc;
    logic [AW-1:0] wr_addr;
    logic          end_hit;
    logic [1:0]    end_status;
    logic [8:0]    count9;
    logic [7:0]    end_len;
    logic          rd_hit;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // Handshake: stage 1 frees when it moves on to the output register
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // Byte append: restart on the first byte, drop once the store is full
    assign base_count = receiving_reg ? count_reg : '0;
    assign base_crc   = receiving_reg ? crc_reg : mrfr_pkg::CRC_INIT;
    assign store_en   = in_fire && (kind == mrfr_pkg::KIND_BYTE)
                        && (!receiving_reg || (count_reg < CW'(FRAME_MAX)));
    assign wr_addr    = base_count[AW-1:0];

    always_comb
    begin
        receiving_next = receiving_reg;
        count_next     = count_reg;
        crc_next       = crc_reg;
        if (in_fire && (kind == mrfr_pkg::KIND_BYTE))
        begin
            receiving_next = 1'b1;
        end
        if (in_fire && (kind == mrfr_pkg::KIND_EXPIRE))
        begin
            receiving_next = 1'b0;
        end
        if (store_en)
        begin
            count_next = base_count + CW'(1);
            crc_next   = mrfr_pkg::crc16_byte(base_crc, rx_byte);
        end
    end

    // Frame close decode
    assign count9   = 9'(count_reg);
    assign end_hit  = (kind == mrfr_pkg::KIND_EXPIRE) && receiving_reg;
    assign end_len  = 8'(count9 - 9'd4);

    always_comb
    begin
        if (count9 < 9'(mrfr_pkg::FRAME_MIN + 1))
            end_status = mrfr_pkg::STATUS_SHORT;
        else if (crc_reg != 16'h0000)
            end_status = mrfr_pkg::STATUS_CRC;
        else
            end_status = mrfr_pkg::STATUS_OK;
    end

    // Data read: index must fall below byte count minus four
    assign rd_hit  = (kind == mrfr_pkg::KIND_READ)
                     && ((10'(data_index) + 10'd4) < 10'(count_reg));
    assign rd_en   = in_fire && rd_hit;
    assign rd_addr = AW'(9'(data_index) + 9'd2);

    mrfr_store #(
        .DEPTH (FRAME_MAX)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            count_reg     <= '0;
            crc_reg       <= mrfr_pkg::CRC_INIT;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            receiving_reg <= receiving_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        // Keep the address and function bytes of the current frame
        if (store_en && (base_count == CW'(0)))
            slave_reg <= rx_byte;
        if (store_en && (base_count == CW'(1)))
            func_reg <= rx_byte;

        // Load stage 1 on transfer
        if (in_fire)
        begin
            s1_ended_reg  <= end_hit;
            s1_notify_reg <= end_hit && awaiting_response;
            s1_status_reg <= end_hit ? end_status : mrfr_pkg::STATUS_OK;
            s1_hit_reg    <= rd_hit;
            if (end_hit && (end_status == mrfr_pkg::STATUS_OK))
            begin
                s1_slave_reg <= slave_reg;
                s1_func_reg  <= func_reg;
                s1_len_reg   <= end_len;
            end
            else
            begin
                s1_slave_reg <= 8'h00;
                s1_func_reg  <= 8'h00;
                s1_len_reg   <= 8'h00;
            end
        end

        // Advance into the output register
        if (advance)
        begin
            ended_reg     <= s1_ended_reg;
            notify_reg    <= s1_notify_reg;
            status_reg    <= s1_status_reg;
            slave_out_reg <= s1_slave_reg;
            func_out_reg  <= s1_func_reg;
            len_reg       <= s1_len_reg;
            read_data_reg <= s1_hit_reg ? rd_data : 8'h00;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_ended     = ended_reg;
    assign notify_response = notify_reg;
    assign frame_status    = status_reg;
    assign slave_id        = slave_out_reg;
    assign function_code   = func_out_reg;
    assign data_length     = len_reg;
    assign read_data       = read_data_reg;

endmodule

>>> hdl/mrfr_checker.sv
// Port-level checks for the Modbus RTU receive framer, bound to the top level.
// Depends on mrfr_pkg.
module mrfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       frame_ended,
    input logic       notify_response,
    input logic [1:0] frame_status,
    input logic [7:0] slave_id,
    input logic [7:0] function_code,
    input logic [7:0] data_length,
    input logic [7:0] read_data
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_status)
            && $stable(read_data) && $stable(slave_id) && $stable(data_length))
    else $error("stalled result changed");

    // Notify and status only come with a closed frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_ended |-> !notify_response
            && (frame_status == mrfr_pkg::STATUS_OK))
    else $error("frame fields set without frame end");

    // Frame header fields are zero unless status is ok
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status != mrfr_pkg::STATUS_OK) |-> (slave_id == 8'h00)
            && (function_code == 8'h00) && (data_length == 8'h00))
    else $error("header fields set on bad frame");

    // A good frame carries at least one data byte; read data never joins a frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_ended |-> (read_data == 8'h00)
            && ((frame_status != mrfr_pkg::STATUS_OK) || (data_length != 8'h00)))
    else $error("frame end result inconsistent");

endmodule

bind modbus_rtu_frame_receiver mrfr_checker u_mrfr_checker (.*);
